// ===== rtl/mkd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared widths, register indexes, the Morse code table and the beat types
// that pass between the tick controller, the code ROM and the result stage.
// ----------------------------------------------------------------------------
package mkd_pkg;

    // Letter buffer geometry.
    localparam int SYMBOL_SLOTS  = 6;
    localparam int TABLE_ENTRIES = 36;
    localparam int TIMER_W       = 16;
    localparam int COUNT_W       = 3;
    localparam int PATTERN_W     = 5;
    localparam int ASCII_W       = 7;
    localparam int CFG_INDEX_W   = 8;

    // Configuration register indexes and reset values.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SAMPLE_DELAY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LETTER_GAP   = 8'd1;
    localparam logic [TIMER_W-1:0]     SAMPLE_DELAY_RESET   = 16'd250;
    localparam logic [TIMER_W-1:0]     LETTER_GAP_RESET     = 16'd3000;

    // Key levels.
    localparam logic KEY_PRESSED  = 1'b0;
    localparam logic KEY_RELEASED = 1'b1;

    // A finished letter handed from the tick controller to the result path.
    typedef struct packed {
        logic                 valid;
        logic [COUNT_W-1:0]   count;
        logic [PATTERN_W-1:0] pattern;
    } mkd_emit_t;

    // Result of a table lookup.
    typedef struct packed {
        logic               hit;
        logic [ASCII_W-1:0] ascii;
    } mkd_code_t;

    // One Morse table entry: symbol count, dash bits and character.
    typedef struct packed {
        logic [COUNT_W-1:0]   len;
        logic [PATTERN_W-1:0] bits;
        logic [ASCII_W-1:0]   ascii;
    } mkd_entry_t;

    localparam mkd_entry_t CODE_TABLE [TABLE_ENTRIES] = '{
        '{3'd2, 5'd2,  7'h41}, '{3'd4, 5'd1,  7'h42}, '{3'd4, 5'd5,  7'h43},
        '{3'd3, 5'd1,  7'h44}, '{3'd1, 5'd0,  7'h45}, '{3'd4, 5'd4,  7'h46},
        '{3'd3, 5'd3,  7'h47}, '{3'd4, 5'd0,  7'h48}, '{3'd2, 5'd0,  7'h49},
        '{3'd4, 5'd14, 7'h4A}, '{3'd3, 5'd5,  7'h4B}, '{3'd4, 5'd2,  7'h4C},
        '{3'd2, 5'd3,  7'h4D}, '{3'd2, 5'd1,  7'h4E}, '{3'd3, 5'd7,  7'h4F},
        '{3'd4, 5'd6,  7'h50}, '{3'd4, 5'd11, 7'h51}, '{3'd3, 5'd2,  7'h52},
        '{3'd3, 5'd0,  7'h53}, '{3'd1, 5'd1,  7'h54}, '{3'd3, 5'd4,  7'h55},
        '{3'd4, 5'd8,  7'h56}, '{3'd3, 5'd6,  7'h57}, '{3'd4, 5'd9,  7'h58},
        '{3'd4, 5'd13, 7'h59}, '{3'd4, 5'd3,  7'h5A}, '{3'd5, 5'd30, 7'h31},
        '{3'd5, 5'd28, 7'h32}, '{3'd5, 5'd24, 7'h33}, '{3'd5, 5'd16, 7'h34},
        '{3'd5, 5'd0,  7'h35}, '{3'd5, 5'd1,  7'h36}, '{3'd5, 5'd3,  7'h37},
        '{3'd5, 5'd7,  7'h38}, '{3'd5, 5'd15, 7'h39}, '{3'd5, 5'd31, 7'h30}
    };

    // Matches a symbol count and dash pattern against the table; the first
    // entry wins, although the entries are all distinct.
    function automatic mkd_code_t mkd_lookup(input logic [COUNT_W-1:0]   count,
                                             input logic [PATTERN_W-1:0] pattern);
        mkd_code_t res;
        res = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (CODE_TABLE[i].len == count && CODE_TABLE[i].bits == pattern) begin
                res.hit   = 1'b1;
                res.ascii = CODE_TABLE[i].ascii;
            end
        end
        return res;
    endfunction

    // A zero delay behaves as one tick.
    function automatic logic [TIMER_W-1:0] mkd_at_least_one(input logic [TIMER_W-1:0] v);
        return (v == '0) ? TIMER_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/mkd_tick_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder tick controller
// Holds the configuration registers, the sample and letter-gap timers and the
// letter buffer, and advances them by one tick for every accepted beat.
// ----------------------------------------------------------------------------
module mkd_tick_ctrl
    import mkd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TIMER_W-1:0]     cfg_data,
    input  wire logic                   tick_en,
    input  wire logic                   key_level,
    output mkd_emit_t                   emit
);

    logic [TIMER_W-1:0]   sample_delay_reg, sample_delay_next;
    logic [TIMER_W-1:0]   letter_gap_reg,   letter_gap_next;
    logic                 last_level_reg,   last_level_next;
    logic [TIMER_W-1:0]   sample_timer_reg, sample_timer_next;
    logic                 sample_active_reg, sample_active_next;
    logic [TIMER_W-1:0]   gap_timer_reg,    gap_timer_next;
    logic                 gap_active_reg,   gap_active_next;
    logic [PATTERN_W-1:0] pattern_reg,      pattern_next;
    logic [COUNT_W-1:0]   count_reg,        count_next;

    logic [TIMER_W-1:0]   sample_dec;
    logic [TIMER_W-1:0]   gap_dec;
    logic                 sample_fire;
    logic                 gap_fire;
    logic [COUNT_W-1:0]   count_inc;
    logic [PATTERN_W-1:0] dash_bit;

    // Configuration writes.
    always_comb begin
        sample_delay_next = sample_delay_reg;
        letter_gap_next   = letter_gap_reg;
        if (cfg_wr) begin
            case (cfg_index)
                CFG_IDX_SAMPLE_DELAY: sample_delay_next = cfg_data;
                CFG_IDX_LETTER_GAP:   letter_gap_next   = cfg_data;
                default: ;
            endcase
        end
    end

    // Expiry detection for both timers.
    assign sample_dec  = sample_timer_reg - TIMER_W'(1);
    assign gap_dec     = gap_timer_reg - TIMER_W'(1);
    assign sample_fire = sample_active_reg && (sample_dec == '0);
    assign gap_fire    = gap_active_reg && !sample_fire && (gap_dec == '0);
    assign count_inc   = count_reg + COUNT_W'(1);
    assign dash_bit    = (count_reg < COUNT_W'(PATTERN_W))
                       ? (PATTERN_W'(1) << count_reg) : '0;

    // One tick: sample timer first, then the gap timer, then the key edge.
    always_comb begin
        last_level_next    = last_level_reg;
        sample_timer_next  = sample_timer_reg;
        sample_active_next = sample_active_reg;
        gap_timer_next     = gap_timer_reg;
        gap_active_next    = gap_active_reg;
        pattern_next       = pattern_reg;
        count_next         = count_reg;
        if (tick_en) begin
            if (sample_active_reg) begin
                sample_timer_next = sample_dec;
            end
            if (sample_fire) begin
                sample_active_next = 1'b0;
                // A sixth symbol empties the buffer.
                if (count_inc >= COUNT_W'(SYMBOL_SLOTS)) begin
                    pattern_next = '0;
                    count_next   = '0;
                end else begin
                    pattern_next = (key_level == KEY_PRESSED) ? (pattern_reg | dash_bit)
                                                              : pattern_reg;
                    count_next   = count_inc;
                end
                gap_timer_next  = mkd_at_least_one(letter_gap_reg);
                gap_active_next = 1'b1;
            end else if (gap_active_reg) begin
                gap_timer_next = gap_dec;
                if (gap_fire) begin
                    gap_active_next = 1'b0;
                    pattern_next    = '0;
                    count_next      = '0;
                end
            end
            if (last_level_reg == KEY_RELEASED && key_level == KEY_PRESSED) begin
                sample_timer_next  = mkd_at_least_one(sample_delay_reg);
                sample_active_next = 1'b1;
            end
            last_level_next = key_level;
        end
    end

    // The finished letter leaves with the buffer as it stood before clearing.
    always_comb begin
        emit.valid   = tick_en && gap_fire;
        emit.count   = count_reg;
        emit.pattern = pattern_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_delay_reg  <= SAMPLE_DELAY_RESET;
            letter_gap_reg    <= LETTER_GAP_RESET;
            last_level_reg    <= KEY_RELEASED;
            sample_timer_reg  <= '0;
            sample_active_reg <= 1'b0;
            gap_timer_reg     <= '0;
            gap_active_reg    <= 1'b0;
            pattern_reg       <= '0;
            count_reg         <= '0;
        end else begin
            sample_delay_reg  <= sample_delay_next;
            letter_gap_reg    <= letter_gap_next;
            last_level_reg    <= last_level_next;
            sample_timer_reg  <= sample_timer_next;
            sample_active_reg <= sample_active_next;
            gap_timer_reg     <= gap_timer_next;
            gap_active_reg    <= gap_active_next;
            pattern_reg       <= pattern_next;
            count_reg         <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mkd_code_rom.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder code ROM
// Synchronous lookup of the Morse table, addressed by symbol count and dash
// pattern, with the read data registered in the cycle after the read strobe.
// ----------------------------------------------------------------------------
module mkd_code_rom
    import mkd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [COUNT_W-1:0]   rd_count,
    input  wire logic [PATTERN_W-1:0] rd_pattern,
    output mkd_code_t                 rd_data
);

    mkd_code_t rd_data_reg;

    // Read data only changes on a strobe, so it holds while the result waits.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mkd_lookup(rd_count, rd_pattern);
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/mkd_result_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder result stage
// Tracks the letter whose ROM read is in flight and the output register that
// presents the finished result beat to the receiver.
// ----------------------------------------------------------------------------
module mkd_result_stage
    import mkd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mkd_emit_t             emit,
    input  wire mkd_code_t             code,
    output logic                       stage_full,
    output logic                       lookup_pending,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_matched,
    output logic [ASCII_W-1:0]         m_char_code,
    output logic [COUNT_W-1:0]         m_symbol_count,
    output logic [PATTERN_W-1:0]       m_symbol_pattern
);

    logic                 p1_valid_reg, p1_valid_next;
    logic [COUNT_W-1:0]   p1_count_reg;
    logic [PATTERN_W-1:0] p1_pattern_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_matched_reg;
    logic [ASCII_W-1:0]   out_char_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [PATTERN_W-1:0] out_pattern_reg;
    logic                 p1_move;

    // The lookup stage may advance whenever the output register is free or
    // is being emptied in this cycle.
    assign p1_move    = !out_valid_reg || m_ready;
    assign stage_full = p1_valid_reg && !p1_move;

    always_comb begin
        p1_valid_next  = p1_valid_reg;
        out_valid_next = out_valid_reg;
        if (emit.valid) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
        if (p1_valid_reg && p1_move) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            p1_count_reg   <= emit.count;
            p1_pattern_reg <= emit.pattern;
        end
        if (p1_valid_reg && p1_move) begin
            out_matched_reg <= code.hit;
            out_char_reg    <= code.ascii;
            out_count_reg   <= p1_count_reg;
            out_pattern_reg <= p1_pattern_reg;
        end
    end

    assign lookup_pending   = p1_valid_reg;
    assign m_valid          = out_valid_reg;
    assign m_matched        = out_matched_reg;
    assign m_char_code      = out_char_reg;
    assign m_symbol_count   = out_count_reg;
    assign m_symbol_pattern = out_pattern_reg;

endmodule
`default_nettype wire

// ===== rtl/morse_key_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Morse key decoder
// Decodes a sampled key line into letters and digits of the Morse alphabet.
// ----------------------------------------------------------------------------
// Each input beat on s_ is one tick carrying the key level (low is pressed).
// One beat is taken per clock while s_ready is high, so a tick stream can run
// at full clock rate. A letter ends when the letter gap timer expires; that
// tick produces one result beat on m_ with the match flag, the ASCII code
// (zero when there is no match), the symbol count and the dash pattern.
// Most ticks produce no result.
// The result of the ending tick passes through the registered read of the
// code ROM and then through the output register, which drives m_valid.
// The cfg_ port writes the sample delay (index 0) and the letter gap
// (index 1); it is always ready and should be used only while idle.
// Reset sets the delays to 250 and 3000 ticks, empties the letter buffer and
// stops both timers. When the receiver stalls, one result waits in the output
// register and one more in the lookup stage; s_ready falls only when both are
// occupied and the output is not taken in that cycle.
// ----------------------------------------------------------------------------
module morse_key_decoder_unit
    import mkd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [TIMER_W-1:0]     cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_key_level,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_matched,
    output logic [ASCII_W-1:0]          m_char_code,
    output logic [COUNT_W-1:0]          m_symbol_count,
    output logic [PATTERN_W-1:0]        m_symbol_pattern
);

    mkd_emit_t emit;
    mkd_code_t code;
    logic      stage_full;
    logic      lookup_pending;
    logic      s_accept;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign s_ready   = !stage_full;
    assign s_accept  = s_valid && s_ready;

    // Timers and letter buffer.
    mkd_tick_ctrl u_tick_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick_en   (s_accept),
        .key_level (s_key_level),
        .emit      (emit)
    );

    // Morse table lookup.
    mkd_code_rom u_code_rom (
        .aclk       (aclk),
        .rd_en      (emit.valid),
        .rd_count   (emit.count),
        .rd_pattern (emit.pattern),
        .rd_data    (code)
    );

    // Lookup stage and output register.
    mkd_result_stage u_result_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .emit             (emit),
        .code             (code),
        .stage_full       (stage_full),
        .lookup_pending   (lookup_pending),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_matched        (m_matched),
        .m_char_code      (m_char_code),
        .m_symbol_count   (m_symbol_count),
        .m_symbol_pattern (m_symbol_pattern)
    );

`ifndef ASSERT_OFF
    // A finished letter is always in the lookup stage on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |=> lookup_pending)
        else $error("finished letter did not enter the lookup stage");

    // Input back-pressure only when both result registers are occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (lookup_pending && m_valid && !m_ready))
        else $error("input stalled without a full result path");

    // A matched result always carries a nonzero character code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_matched) |-> (m_char_code != '0))
        else $error("matched result with empty character code");

    // The symbol count never exceeds the letter buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_symbol_count < COUNT_W'(SYMBOL_SLOTS)))
        else $error("result symbol count out of range");
`endif

endmodule
`default_nettype wire

// ===== sim/tb_morse_key_decoder_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse key decoder testbench
// Streams key-level ticks into the decoder under a range of sample-delay and
// letter-gap settings. A scoreboard predicts every letter beat from its own
// model of the timers and the letter buffer, and compares each result beat
// field by field. Both handshakes idle at random, and the receiver stalls
// once for long enough to fill the block and push back on the tick stream.
// ----------------------------------------------------------------------------

import mkd_pkg::*;

// One expected or observed letter beat.
typedef struct {
    logic                 matched;
    logic [ASCII_W-1:0]   char_code;
    logic [COUNT_W-1:0]   symbol_count;
    logic [PATTERN_W-1:0] symbol_pattern;
} letter_t;

// Morse alphabet: symbol count, dash bits (bit i is symbol i) and character.
typedef struct packed {
    logic [COUNT_W-1:0]   len;
    logic [PATTERN_W-1:0] dashes;
    logic [ASCII_W-1:0]   ascii;
} morse_row_t;

localparam morse_row_t MORSE_ROWS [36] = '{
    '{3'd2, 5'd2,  7'h41}, '{3'd4, 5'd1,  7'h42}, '{3'd4, 5'd5,  7'h43},
    '{3'd3, 5'd1,  7'h44}, '{3'd1, 5'd0,  7'h45}, '{3'd4, 5'd4,  7'h46},
    '{3'd3, 5'd3,  7'h47}, '{3'd4, 5'd0,  7'h48}, '{3'd2, 5'd0,  7'h49},
    '{3'd4, 5'd14, 7'h4A}, '{3'd3, 5'd5,  7'h4B}, '{3'd4, 5'd2,  7'h4C},
    '{3'd2, 5'd3,  7'h4D}, '{3'd2, 5'd1,  7'h4E}, '{3'd3, 5'd7,  7'h4F},
    '{3'd4, 5'd6,  7'h50}, '{3'd4, 5'd11, 7'h51}, '{3'd3, 5'd2,  7'h52},
    '{3'd3, 5'd0,  7'h53}, '{3'd1, 5'd1,  7'h54}, '{3'd3, 5'd4,  7'h55},
    '{3'd4, 5'd8,  7'h56}, '{3'd3, 5'd6,  7'h57}, '{3'd4, 5'd9,  7'h58},
    '{3'd4, 5'd13, 7'h59}, '{3'd4, 5'd3,  7'h5A}, '{3'd5, 5'd30, 7'h31},
    '{3'd5, 5'd28, 7'h32}, '{3'd5, 5'd24, 7'h33}, '{3'd5, 5'd16, 7'h34},
    '{3'd5, 5'd0,  7'h35}, '{3'd5, 5'd1,  7'h36}, '{3'd5, 5'd3,  7'h37},
    '{3'd5, 5'd7,  7'h38}, '{3'd5, 5'd15, 7'h39}, '{3'd5, 5'd31, 7'h30}
};

// Keeps its own copy of the decoder state and the queue of letters due.
class letter_scoreboard;
    logic [TIMER_W-1:0]   sample_delay;
    logic [TIMER_W-1:0]   letter_gap;
    logic                 last_level;
    logic [TIMER_W-1:0]   sample_left;
    logic                 sample_run;
    logic [TIMER_W-1:0]   gap_left;
    logic                 gap_run;
    logic [PATTERN_W-1:0] dash_bits;
    logic [COUNT_W-1:0]   symbols;
    letter_t              letters_due[$];
    int                   mismatches;
    int                   ticks;
    int                   letters;
    int                   decoded;

    function new();
        sample_delay = SAMPLE_DELAY_RESET;
        letter_gap   = LETTER_GAP_RESET;
        last_level   = KEY_RELEASED;
        sample_left  = '0;
        sample_run   = 1'b0;
        gap_left     = '0;
        gap_run      = 1'b0;
        dash_bits    = '0;
        symbols      = '0;
        mismatches   = 0;
        ticks        = 0;
        letters      = 0;
        decoded      = 0;
    endfunction

    function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [TIMER_W-1:0] data);
        if (idx == CFG_IDX_SAMPLE_DELAY)
            sample_delay = data;
        else if (idx == CFG_IDX_LETTER_GAP)
            letter_gap = data;
    endfunction

    // Advances the model by one accepted tick and queues any letter it ends.
    function void note_tick(input logic level);
        logic    took;
        int      next_count;
        letter_t res;
        took = 1'b0;
        ticks++;

        // Sample timer: its expiry turns the key level into a symbol.
        if (sample_run) begin
            sample_left = sample_left - 1'b1;
            if (sample_left == '0) begin
                sample_run = 1'b0;
                took       = 1'b1;
                if (level == KEY_PRESSED)
                    dash_bits = dash_bits | (PATTERN_W'(1) << symbols);
                next_count = int'(symbols) + 1;
                if (next_count >= SYMBOL_SLOTS) begin
                    dash_bits = '0;
                    symbols   = '0;
                end else begin
                    symbols = COUNT_W'(next_count);
                end
                gap_left = (letter_gap == '0) ? TIMER_W'(1) : letter_gap;
                gap_run  = 1'b1;
            end
        end

        // Letter gap: a fresh symbol on this tick holds the letter open.
        if (gap_run && !took) begin
            gap_left = gap_left - 1'b1;
            if (gap_left == '0) begin
                gap_run = 1'b0;
                res = '{1'b0, '0, symbols, dash_bits};
                foreach (MORSE_ROWS[i]) begin
                    if (!res.matched && MORSE_ROWS[i].len == symbols &&
                        MORSE_ROWS[i].dashes == dash_bits) begin
                        res.matched   = 1'b1;
                        res.char_code = MORSE_ROWS[i].ascii;
                    end
                end
                letters_due.push_back(res);
                dash_bits = '0;
                symbols   = '0;
            end
        end

        // A press (released to pressed) starts or restarts the sample timer.
        if (last_level == KEY_RELEASED && level == KEY_PRESSED) begin
            sample_left = (sample_delay == '0) ? TIMER_W'(1) : sample_delay;
            sample_run  = 1'b1;
        end
        last_level = level;
    endfunction

    function void check_result(input letter_t got);
        letter_t want;
        if (letters_due.size() == 0) begin
            $display("%0t: letter beat with none due: matched=%0d char=%h count=%0d pattern=%b",
                     $time, got.matched, got.char_code, got.symbol_count, got.symbol_pattern);
            mismatches++;
            return;
        end
        want = letters_due.pop_front();
        letters++;
        if (want.matched)
            decoded++;
        if (got.matched !== want.matched) begin
            $display("%0t: matched expected %0d actual %0d", $time, want.matched, got.matched);
            mismatches++;
        end
        if (got.char_code !== want.char_code) begin
            $display("%0t: char_code expected %h actual %h", $time, want.char_code,
                     got.char_code);
            mismatches++;
        end
        if (got.symbol_count !== want.symbol_count) begin
            $display("%0t: symbol_count expected %0d actual %0d", $time, want.symbol_count,
                     got.symbol_count);
            mismatches++;
        end
        if (got.symbol_pattern !== want.symbol_pattern) begin
            $display("%0t: symbol_pattern expected %b actual %b", $time, want.symbol_pattern,
                     got.symbol_pattern);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return letters_due.size();
    endfunction
endclass

module tb_morse_key_decoder_unit;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [TIMER_W-1:0]     cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_key_level;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_matched;
    logic [ASCII_W-1:0]     m_char_code;
    logic [COUNT_W-1:0]     m_symbol_count;
    logic [PATTERN_W-1:0]   m_symbol_pattern;

    letter_scoreboard sb = new();
    letter_t          seen;

    logic [TIMER_W-1:0] cur_sample = SAMPLE_DELAY_RESET;
    logic [TIMER_W-1:0] cur_gap    = LETTER_GAP_RESET;
    int                 ticks_in_phase;
    int                 settings;
    int                 stall_cycles;
    int                 hold_left;
    bit                 quiet_run;
    bit                 hold_wanted;
    bit                 hold_done;

    morse_key_decoder_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_level      (s_key_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_matched        (m_matched),
        .m_char_code      (m_char_code),
        .m_symbol_count   (m_symbol_count),
        .m_symbol_pattern (m_symbol_pattern)
    );

    always #6 aclk = ~aclk;

    // Effective timer lengths as the block applies them.
    function automatic int unsigned delay_ticks();
        return (cur_sample == '0) ? 1 : int'(cur_sample);
    endfunction

    function automatic int unsigned gap_ticks();
        return (cur_gap == '0) ? 1 : int'(cur_gap);
    endfunction

    // Offers one tick beat, with random idle cycles ahead of it.
    task automatic send_tick(input logic level);
        @(negedge aclk);
        while (!quiet_run && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_key_level <= level;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_tick(level);
        ticks_in_phase++;
    endtask

    // A press held through the sampling tick is a dash; released by then, a dot.
    task automatic send_symbol(input bit dash, input int unsigned d);
        int unsigned hold;
        hold = dash ? d : d - 1;
        if (dash && $urandom_range(9) == 0)
            hold = d + 1;
        send_tick(KEY_PRESSED);
        repeat (hold)
            send_tick(KEY_PRESSED);
        send_tick(KEY_RELEASED);
    endtask

    task automatic send_letter(input int count, input logic [7:0] dashes, input int spread);
        for (int i = 0; i < count; i++) begin
            send_symbol(dashes[i], delay_ticks());
            repeat ($urandom_range(spread))
                send_tick(KEY_RELEASED);
        end
        repeat (gap_ticks() + $urandom_range(2))
            send_tick(KEY_RELEASED);
    endtask

    // Mostly keyed letters, some odd symbol counts and some raw noise.
    task automatic offer_random(input int n);
        int         pick;
        morse_row_t row;
        ticks_in_phase = 0;
        while (ticks_in_phase < n) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                row = MORSE_ROWS[$urandom_range(35)];
                send_letter(row.len, {3'b000, row.dashes}, 2);
            end else if (pick < 85) begin
                send_letter($urandom_range(7), 8'($urandom), 2);
            end else begin
                repeat ($urandom_range(12, 1))
                    send_tick(1'($urandom));
            end
        end
    endtask

    // Drains every due letter, lets the pipeline empty, then writes both timers.
    task automatic configure(input logic [TIMER_W-1:0] sample, input logic [TIMER_W-1:0] gap);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_SAMPLE_DELAY;
        cfg_data  <= sample;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(CFG_IDX_SAMPLE_DELAY, sample);
        @(negedge aclk);
        cfg_index <= CFG_IDX_LETTER_GAP;
        cfg_data  <= gap;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        sb.write_reg(CFG_IDX_LETTER_GAP, gap);
        @(negedge aclk);
        cfg_valid  <= 1'b0;
        cur_sample = sample;
        cur_gap    = gap;
        settings++;
    endtask

    // Receiver: random ready, one long hold-off on request.
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_done) begin
            m_ready   <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_ready <= quiet_run || ($urandom_range(99) >= 26);
        end
    end

    // Result monitor and stall counter.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen = '{m_matched, m_char_code, m_symbol_count, m_symbol_pattern};
            sb.check_result(seen);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog on handshake progress.
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_key_level = KEY_RELEASED;
        settings    = 0;
        stall_cycles = 0;
        hold_left   = 0;
        quiet_run   = 1'b0;
        hold_wanted = 1'b0;
        hold_done   = 1'b0;
        repeat (7)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // A short press under the reset timer values; no letter may appear yet.
        repeat (20)
            send_tick(KEY_PRESSED);
        repeat (20)
            send_tick(KEY_RELEASED);

        // Directed: a dot, a dash, and six dots that overflow the buffer.
        configure(16'd1, 16'd3);
        send_letter(1, 8'd0, 0);
        send_letter(1, 8'd1, 0);
        send_letter(6, 8'd0, 0);

        // Zero in both registers behaves as one tick.
        configure(16'd0, 16'd0);
        offer_random(120);

        // A stretch with no idling on either side.
        configure(16'd2, 16'd5);
        quiet_run = 1'b1;
        offer_random(220);
        quiet_run = 1'b0;

        // The receiver stalls long enough to back up the tick stream.
        configure(16'd3, 16'd12);
        hold_wanted = 1'b1;
        offer_random(220);

        // Sampling often lands on the same tick the gap would expire.
        configure(16'd1, 16'd2);
        offer_random(150);

        // Full-scale sample delay, then full-scale letter gap; both timers are
        // left running and are restarted under the next setting.
        configure(16'hFFFF, 16'd1);
        repeat (16)
            send_tick(KEY_PRESSED);
        send_tick(KEY_RELEASED);
        configure(16'd1, 16'hFFFF);
        send_symbol(1'b0, delay_ticks());
        repeat (16)
            send_tick(KEY_RELEASED);

        configure(16'd4, 16'd9);
        offer_random(130);

        configure(SAMPLE_DELAY_RESET, LETTER_GAP_RESET);

        $display("Covered %0d key ticks and %0d letter beats (%0d decoded, %0d unmatched)",
                 sb.ticks, sb.letters, sb.decoded, sb.letters - sb.decoded);
        $display("over %0d timer settings from zero to full scale, with one long output stall.",
                 settings);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
